@@ src/jcws_pkg.sv @@
// jcws_pkg: shared types and character constants for the json comment and whitespace skipper
// no dependencies; imported by every module of the block
package jcws_pkg;

   localparam int RSP_DEPTH = 4;

   localparam logic [15:0] CH_NUL   = 16'h0000;
   localparam logic [15:0] CH_LF    = 16'h000A;
   localparam logic [15:0] CH_CR    = 16'h000D;
   localparam logic [15:0] CH_SPACE = 16'h0020;
   localparam logic [15:0] CH_HASH  = 16'h0023;
   localparam logic [15:0] CH_STAR  = 16'h002A;
   localparam logic [15:0] CH_SLASH = 16'h002F;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_LINE    = 3'd2,
      MODE_BLOCK   = 3'd3,
      MODE_STAR    = 3'd4,
      MODE_PENDING = 3'd5
   } mode_type;

   typedef struct packed {
      logic [15:0] ch;
      kind_type    kind;
      logic        last;
   } rsp_type;

   // results of one accepted transaction, at most two
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } step_out_type;

endpackage

@@ src/json_comment_whitespace_skipper.sv @@
// json_comment_whitespace_skipper: results of an accepted transaction are written to the result
// queue; one character accepted per cycle while the four-entry result queue has room for two;
// results leave one per cycle while rsp_stall is low. synchronous active-high reset returns
// to normal scan mode and empties queue
// depends on jcws_pkg, jcws_step, jcws_rsp_fifo
module json_comment_whitespace_skipper
   import jcws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input transactions, one text character each
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_ch,
   input  logic        req_end_of_text,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_char,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last
);

   step_out_type step_out;
   rsp_type      rsp_head;
   logic         room;
   logic         accept;

   // stall comes from queue occupancy only, so it never waits on the output side
   assign req_stall = !room;
   assign accept    = req_valid && room;

   // decision logic: scan mode register plus the character classification
   jcws_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .step_out    (step_out)
   );

   // result queue, doubles as the output register
   jcws_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_head  (rsp_head)
   );

   assign rsp_out_char = rsp_head.ch;
   assign rsp_kind     = rsp_head.kind;
   assign rsp_last     = rsp_head.last;

endmodule

@@ src/jcws_step.sv @@
// jcws_step: scan mode register and the per-character decision logic
// depends on jcws_pkg
module jcws_step
   import jcws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [15:0]  ch,
   input  logic         end_of_text,
   output step_out_type step_out
);

   typedef struct packed {
      mode_type mode;
      logic     emit;
      kind_type kind;
      logic     ended;
   } normal_type;

   mode_type mode_ff, mode_in;

   function automatic normal_type take_normal(input logic [15:0] c);
      normal_type t;
      t.mode  = MODE_NORMAL;
      t.emit  = 1'b0;
      t.kind  = KIND_CHAR;
      t.ended = 1'b0;
      if (c == CH_NUL) begin
         t.emit  = 1'b1;
         t.kind  = KIND_END;
         t.ended = 1'b1;
      end else if (c == CH_SLASH) begin
         t.mode = MODE_SLASH;
      end else if (c == CH_HASH) begin
         t.mode = MODE_LINE;
      end else if (c > CH_SPACE) begin
         t.emit = 1'b1;
      end
      return t;
   endfunction

   rsp_type    res [3];
   logic [1:0] cnt;
   logic       ended;
   mode_type   eff;
   normal_type tn;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res[i] = '{ch: CH_NUL, kind: KIND_CHAR, last: 1'b0};
      end
      cnt     = 2'd0;
      ended   = 1'b0;
      mode_in = mode_ff;
      eff     = mode_ff;
      tn      = take_normal(ch);

      // deferred end marker goes out first
      if (mode_ff == MODE_PENDING) begin
         res[cnt].kind = KIND_END;
         cnt           = cnt + 2'd1;
         mode_in       = MODE_NORMAL;
         eff           = MODE_NORMAL;
      end

      case (eff)
         MODE_SLASH: begin
            if (ch == CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (ch == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               res[cnt].ch   = CH_SLASH;
               res[cnt].kind = KIND_CHAR;
               cnt           = cnt + 2'd1;
               mode_in       = tn.mode;
               ended         = tn.ended;
               if (tn.emit) begin
                  res[cnt].kind = tn.kind;
                  res[cnt].ch   = (tn.kind == KIND_CHAR) ? ch : CH_NUL;
                  cnt           = cnt + 2'd1;
               end
            end
         end
         MODE_LINE: begin
            if (ch == CH_NUL) begin
               mode_in       = MODE_NORMAL;
               res[cnt].kind = KIND_END;
               cnt           = cnt + 2'd1;
               ended         = 1'b1;
            end else if (ch == CH_LF || ch == CH_CR) begin
               mode_in = MODE_NORMAL;
            end else begin
               mode_in = MODE_LINE;
            end
         end
         MODE_BLOCK, MODE_STAR: begin
            if (ch == CH_NUL) begin
               mode_in       = MODE_NORMAL;
               res[cnt].kind = KIND_ERROR;
               cnt           = cnt + 2'd1;
               ended         = 1'b1;
            end else if (ch == CH_STAR) begin
               mode_in = MODE_STAR;
            end else if (eff == MODE_STAR && ch == CH_SLASH) begin
               mode_in = MODE_NORMAL;
            end else begin
               mode_in = MODE_BLOCK;
            end
         end
         default: begin
            mode_in = tn.mode;
            ended   = tn.ended;
            if (tn.emit) begin
               res[cnt].kind = tn.kind;
               res[cnt].ch   = (tn.kind == KIND_CHAR) ? ch : CH_NUL;
               cnt           = cnt + 2'd1;
            end
         end
      endcase

      if (end_of_text && !ended) begin
         if (mode_in == MODE_BLOCK || mode_in == MODE_STAR) begin
            res[cnt].kind = KIND_ERROR;
            cnt           = cnt + 2'd1;
         end else begin
            if (mode_in == MODE_SLASH) begin
               res[cnt].ch   = CH_SLASH;
               res[cnt].kind = KIND_CHAR;
               cnt           = cnt + 2'd1;
            end
            res[cnt].kind = KIND_END;
            cnt           = cnt + 2'd1;
         end
         mode_in = MODE_NORMAL;
      end

      // third result is always an end marker, hold it for the next transaction
      if (cnt == 2'd3) begin
         cnt     = 2'd2;
         mode_in = MODE_PENDING;
      end

      res[0].last = (cnt == 2'd1);
      res[1].last = (cnt == 2'd2);

      step_out.count = cnt;
      step_out.res0  = res[0];
      step_out.res1  = res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

@@ src/jcws_rsp_fifo.sv @@
// jcws_rsp_fifo: small result queue, takes up to two results a cycle, gives one
// depends on jcws_pkg
module jcws_rsp_fifo
   import jcws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type step_out,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_head
);

   localparam int PW = $clog2(RSP_DEPTH);
   localparam int CW = $clog2(RSP_DEPTH + 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(RSP_DEPTH - 2);

   rsp_type         mem_ff [RSP_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            pop;
   logic [1:0]      n_push;

   assign n_push    = push ? step_out.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= ROOM_MAX);
   assign rsp_head  = mem_ff[rp_ff];

   always_comb begin
      wp_in    = wp_ff + PW'(n_push);
      rp_in    = rp_ff + PW'(pop);
      count_in = count_ff + CW'(n_push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push && step_out.count != 2'd0) begin
         mem_ff[wp_ff] <= step_out.res0;
      end
      if (push && step_out.count == 2'd2) begin
         mem_ff[wp_ff + PW'(1)] <= step_out.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/jcws_checker.sv @@
// jcws_checker: port-level assertions for the skipper, bound to the top level
// depends on jcws_pkg and json_comment_whitespace_skipper
module jcws_checker
   import jcws_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_char,
   input logic [1:0]  rsp_kind,
   input logic        rsp_last
);

   // queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // markers carry a zero character
   a_marker_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CHAR |-> rsp_out_char == CH_NUL)
      else $error("end or error result with nonzero character");

   // an error always closes its transaction
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_last)
      else $error("error result not last");

   // no whitespace or control codes are passed on
   a_no_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHAR |-> rsp_out_char > CH_SPACE)
      else $error("blank character passed on");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_kind)
         && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind json_comment_whitespace_skipper jcws_checker u_jcws_checker (.*);
